@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is asserted.
`define ALCS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Next-cycle implication check.
`define ALCS_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/alcs_pkg.sv @@
// Shared types and constants for the auto-level contrast stretch block.
`timescale 1ns / 1ps

package alcs_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_W    = 2 * CHAN_W;
    localparam int unsigned DIV_STEPS = CHAN_W;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_STEPS - 1);

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } alcs_state_t;

    // Control from the sequencer to each channel lane.
    typedef struct packed {
        logic start;
        logic measure;
        logic first;
    } lane_ctrl_t;

    // What a lane hands back to the merge stage.
    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] value;
    } lane_res_t;

endpackage

@@ rtl/alcs_lane.sv @@
// One color channel: running min/max statistics and a radix-2 stretch divider.
`timescale 1ns / 1ps

module alcs_lane
    import alcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  lane_ctrl_t        ctrl,
    input  logic [CHAN_W-1:0] pix,
    output lane_res_t         res
);

    logic [CHAN_W-1:0] min_reg, min_next;
    logic [CHAN_W-1:0] max_reg, max_next;
    logic [CHAN_W-1:0] den_reg, den_next;
    logic [CHAN_W-1:0] rem_reg, rem_next;
    logic [CHAN_W-1:0] lo_reg,  lo_next;
    logic [CHAN_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              zero_reg, zero_next;
    logic              sat_reg,  sat_next;

    logic [CHAN_W-1:0] diff;
    logic [NUM_W-1:0]  num;
    logic [CHAN_W:0]   trial;
    logic [CHAN_W:0]   trial_sub;
    logic              fits;

    // (v - min) * 255 as (x << 8) - x
    assign diff      = pix - min_reg;
    assign num       = {diff, CHAN_ZERO} - {CHAN_ZERO, diff};
    assign trial     = {rem_reg, lo_reg[CHAN_W-1]};
    assign fits      = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb begin
        min_next  = min_reg;
        max_next  = max_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        zero_next = zero_reg;
        sat_next  = sat_reg;

        if (ctrl.measure) begin
            if (ctrl.first) begin
                min_next = pix;
                max_next = pix;
            end else begin
                if (pix < min_reg) min_next = pix;
                if (pix > max_reg) max_next = pix;
            end
        end

        if (ctrl.start) begin
            // empty range or value at/below min gives 0; above max saturates
            zero_next = (max_reg <= min_reg) || (pix <= min_reg);
            sat_next  = (pix > max_reg);
            den_next  = max_reg - min_reg;
            rem_next  = num[NUM_W-1:CHAN_W];
            lo_next   = num[CHAN_W-1:0];
            quo_next  = CHAN_ZERO;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = fits ? trial_sub[CHAN_W-1:0] : trial[CHAN_W-1:0];
            lo_next  = {lo_reg[CHAN_W-2:0], 1'b0};
            quo_next = {quo_reg[CHAN_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= CHAN_MAX;
            max_reg  <= CHAN_ZERO;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            min_reg  <= min_next;
            max_reg  <= max_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
        sat_reg  <= sat_next;
    end

    always_comb begin
        res.done = done_reg;
        if (zero_reg) begin
            res.value = CHAN_ZERO;
        end else if (sat_reg) begin
            res.value = CHAN_MAX;
        end else begin
            res.value = quo_reg;
        end
    end

endmodule

@@ rtl/auto_level_contrast_stretch.sv @@
// Top level: request sequencer, three channel lanes and the output merge register.
// An apply request loads the lanes, runs the eight-step radix-2 divider in each lane
// and shows its pixel on m_valid from the output register. Measure requests are taken
// one per cycle while idle; an apply request blocks input until its pixel is loaded.
// The output register lets the next request in while a pixel waits on m_ready.
// Reset (aresetn low, synchronous) sets min to 255, max to 0 and clears all valids.
`timescale 1ns / 1ps

module auto_level_contrast_stretch
    import alcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  logic              s_first,
    input  logic [CHAN_W-1:0] s_red_in,
    input  logic [CHAN_W-1:0] s_green_in,
    input  logic [CHAN_W-1:0] s_blue_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_red_out,
    output logic [CHAN_W-1:0] m_green_out,
    output logic [CHAN_W-1:0] m_blue_out
);

    alcs_state_t state_reg, state_next;

    logic              m_valid_reg, m_valid_next;
    logic [CHAN_W-1:0] red_reg, green_reg, blue_reg;
    logic              take;
    logic              load_out;
    logic              out_free;
    lane_ctrl_t        ctrl;
    lane_res_t         red_res, green_res, blue_res;

    assign take     = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign ctrl.start   = take && (s_action == ACT_APPLY);
    assign ctrl.measure = take && (s_action == ACT_MEASURE);
    assign ctrl.first   = s_first;

    alcs_lane u_red (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .pix     (s_red_in),
        .res     (red_res)
    );

    alcs_lane u_green (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .pix     (s_green_in),
        .res     (green_res)
    );

    alcs_lane u_blue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .pix     (s_blue_in),
        .res     (blue_res)
    );

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (ctrl.start) state_next = ST_DIV;
            end
            ST_DIV: begin
                // lanes run in lockstep, so any lane's done stands for all
                if (red_res.done && green_res.done && blue_res.done) begin
                    if (out_free) begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            red_reg   <= red_res.value;
            green_reg <= green_res.value;
            blue_reg  <= blue_res.value;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = red_reg;
    assign m_green_out = green_reg;
    assign m_blue_out  = blue_reg;

endmodule

@@ rtl/alcs_checker.sv @@
// Port-level checker for the contrast stretch block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alcs_checker
    import alcs_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_action,
    input logic              m_valid,
    input logic              m_ready,
    input logic [CHAN_W-1:0] m_red_out,
    input logic [CHAN_W-1:0] m_green_out,
    input logic [CHAN_W-1:0] m_blue_out
);

    logic                take;
    logic [3*CHAN_W-1:0] m_pix;

    assign take  = s_valid && s_ready;
    assign m_pix = {m_red_out, m_green_out, m_blue_out};

    // stalled result keeps its pixel
    `ALCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pix))

    // a measure request never stalls the input side
    `ALCS_ASSERT_NEXT(a_measure_ready, aclk, aresetn, take && (s_action == ACT_MEASURE), s_ready)

    // an apply request blocks the input while the divider runs
    `ALCS_ASSERT_NEXT(a_apply_busy, aclk, aresetn, take && (s_action == ACT_APPLY), !s_ready)

    // a result never appears right behind an accepted request
    `ALCS_ASSERT(a_no_early_out, aclk, aresetn, $rose(m_valid) |-> !$past(take))

endmodule

bind auto_level_contrast_stretch alcs_checker u_alcs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_action    (s_action),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_red_out   (m_red_out),
    .m_green_out (m_green_out),
    .m_blue_out  (m_blue_out)
);

@@ sim/alcs_stretch_checker.sv @@
// Checker for the auto-level stretch block: tracks levels, predicts pixels, compares.
`timescale 1ns / 1ps

module alcs_stretch_checker
    import alcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_action,
    input  logic              s_first,
    input  logic [CHAN_W-1:0] s_red_in,
    input  logic [CHAN_W-1:0] s_green_in,
    input  logic [CHAN_W-1:0] s_blue_in,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [CHAN_W-1:0] m_red_out,
    input  logic [CHAN_W-1:0] m_green_out,
    input  logic [CHAN_W-1:0] m_blue_out,
    output int                err_count,
    output int                pending
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    pixel_t            stretched_q[$];
    logic [CHAN_W-1:0] level_lo [3];
    logic [CHAN_W-1:0] level_hi [3];
    int                mismatches = 0;

    initial begin
        err_count = 0;
        pending   = 0;
    end

    function automatic logic [CHAN_W-1:0] level_map(input logic [CHAN_W-1:0] v,
                                                    input logic [CHAN_W-1:0] lo,
                                                    input logic [CHAN_W-1:0] hi);
        logic [NUM_W-1:0] q;
        // flat channel or value at/below the floor maps to black
        if (hi <= lo || v <= lo)
            return CHAN_ZERO;
        q = (NUM_W'(v - lo) * NUM_W'(CHAN_MAX)) / NUM_W'(hi - lo);
        if (q > NUM_W'(CHAN_MAX))
            return CHAN_MAX;
        return q[CHAN_W-1:0];
    endfunction

    always @(posedge aclk) begin
        pixel_t            want;
        logic [CHAN_W-1:0] pix [3];
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                level_lo[i] = CHAN_MAX;
                level_hi[i] = CHAN_ZERO;
            end
            stretched_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                pix[0] = s_red_in;
                pix[1] = s_green_in;
                pix[2] = s_blue_in;
                if (s_action == ACT_MEASURE) begin
                    for (int i = 0; i < 3; i++) begin
                        if (s_first) begin
                            level_lo[i] = pix[i];
                            level_hi[i] = pix[i];
                        end else begin
                            if (pix[i] < level_lo[i]) level_lo[i] = pix[i];
                            if (pix[i] > level_hi[i]) level_hi[i] = pix[i];
                        end
                    end
                end else begin
                    want.red   = level_map(pix[0], level_lo[0], level_hi[0]);
                    want.green = level_map(pix[1], level_lo[1], level_hi[1]);
                    want.blue  = level_map(pix[2], level_lo[2], level_hi[2]);
                    stretched_q.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                if (stretched_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $realtime,
                                 m_red_out, m_green_out, m_blue_out);
                end else begin
                    want = stretched_q.pop_front();
                    if (want.red != m_red_out || want.green != m_green_out ||
                        want.blue != m_blue_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     m_red_out, m_green_out, m_blue_out);
                    end
                end
            end
        end
        err_count <= mismatches;
        pending   <= stretched_q.size();
    end

endmodule

@@ sim/auto_level_contrast_stretch_test.sv @@
// Testbench top: clock, reset, request stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module auto_level_contrast_stretch_test;
    import alcs_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 400;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic              s_action    = ACT_MEASURE;
    logic              s_first     = 1'b0;
    logic [CHAN_W-1:0] s_red_in    = '0;
    logic [CHAN_W-1:0] s_green_in  = '0;
    logic [CHAN_W-1:0] s_blue_in   = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic [CHAN_W-1:0] m_red_out;
    logic [CHAN_W-1:0] m_green_out;
    logic [CHAN_W-1:0] m_blue_out;

    int   err_count;
    int   pending;
    int   rx_stall_pct = 0;
    int   tx_idle_pct  = 0;
    int   items_sent   = 0;
    logic hold_tok     = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    auto_level_contrast_stretch dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_first     (s_first),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out)
    );

    alcs_stretch_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_first     (s_first),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .err_count   (err_count),
        .pending     (pending)
    );

    // Output back-pressure; a hold token starts one long stall counted here.
    always @(posedge aclk) begin
        if (hold_tok != hold_seen) begin
            hold_seen <= hold_tok;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic push_pixel(input logic act, input logic first,
                              input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_first    <= first;
        s_red_in   <= r;
        s_green_in <= g;
        s_blue_in  <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic [CHAN_W-1:0] pick_level(input int lo, input int hi);
        return CHAN_W'($urandom_range(hi, lo));
    endfunction

    initial begin
        int win_lo [3];
        int win_hi [3];
        int n_meas;
        int n_apply;
        int phase;
        logic [CHAN_W-1:0] pv [3];

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stats still at reset values: everything maps to zero, first ignored on apply
        push_pixel(ACT_APPLY,   1'b0, 8'd0,   8'd0,   8'd0);
        push_pixel(ACT_APPLY,   1'b1, 8'd255, 8'd255, 8'd255);
        // red 10..250, green 5..200, blue flat at 77
        push_pixel(ACT_MEASURE, 1'b1, 8'd10,  8'd200, 8'd77);
        push_pixel(ACT_MEASURE, 1'b0, 8'd250, 8'd5,   8'd77);
        push_pixel(ACT_APPLY,   1'b0, 8'd10,  8'd5,   8'd77);
        push_pixel(ACT_APPLY,   1'b0, 8'd250, 8'd200, 8'd255);
        push_pixel(ACT_APPLY,   1'b0, 8'd0,   8'd0,   8'd0);
        push_pixel(ACT_APPLY,   1'b0, 8'd255, 8'd255, 8'd100);
        push_pixel(ACT_APPLY,   1'b0, 8'd130, 8'd100, 8'd78);
        push_pixel(ACT_APPLY,   1'b1, 8'd11,  8'd199, 8'd76);
        // full range after restart
        push_pixel(ACT_MEASURE, 1'b1, 8'd0,   8'd0,   8'd0);
        push_pixel(ACT_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
        push_pixel(ACT_APPLY,   1'b0, 8'd0,   8'd255, 8'd128);
        push_pixel(ACT_APPLY,   1'b0, 8'd1,   8'd254, 8'd127);
        // restart to a single level: every channel flat
        push_pixel(ACT_MEASURE, 1'b1, 8'd128, 8'd128, 8'd128);
        push_pixel(ACT_APPLY,   1'b0, 8'd200, 8'd128, 8'd0);
        // widen without restart
        push_pixel(ACT_MEASURE, 1'b0, 8'h55,  8'hAA,  8'h0F);
        push_pixel(ACT_APPLY,   1'b0, 8'hAA,  8'h55,  8'hF0);

        // fill the block while the output is held off
        hold_tok <= ~hold_tok;
        for (int i = 0; i < 14; i++)
            push_pixel(ACT_APPLY, 1'($urandom_range(1)), pick_level(0, 255),
                       pick_level(0, 255), pick_level(0, 255));

        while (items_sent < RANDOM_ITEMS) begin
            phase = (items_sent * 4) / RANDOM_ITEMS;
            case (phase)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1: begin
                    tx_idle_pct = 48;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 48;
                end
                default: begin
                    tx_idle_pct = 6;
                    rx_stall_pct <= 6;
                end
            endcase

            if ($urandom_range(99) < 80) begin
                // well-formed frame: measure pass, then apply pass
                for (int c = 0; c < 3; c++) begin
                    win_lo[c] = $urandom_range(255);
                    win_hi[c] = ($urandom_range(9) == 0) ? win_lo[c]
                                                         : $urandom_range(255, win_lo[c]);
                end
                n_meas  = $urandom_range(12, 1);
                n_apply = $urandom_range(12, 1);
                for (int i = 0; i < n_meas; i++) begin
                    for (int c = 0; c < 3; c++)
                        pv[c] = pick_level(win_lo[c], win_hi[c]);
                    push_pixel(ACT_MEASURE, (i == 0), pv[0], pv[1], pv[2]);
                end
                for (int i = 0; i < n_apply; i++) begin
                    for (int c = 0; c < 3; c++)
                        pv[c] = ($urandom_range(1) == 0) ? pick_level(0, 255)
                                                         : pick_level(win_lo[c], win_hi[c]);
                    push_pixel(ACT_APPLY, 1'($urandom_range(1)), pv[0], pv[1], pv[2]);
                end
            end else begin
                // noise: arbitrary mix of requests
                n_meas = $urandom_range(8, 1);
                for (int i = 0; i < n_meas; i++)
                    push_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                               pick_level(0, 255), pick_level(0, 255), pick_level(0, 255));
            end
        end

        s_valid <= 1'b0;
        rx_stall_pct <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
